[design/atan2_rational_approx_macros.svh]
// Assertion helpers for the design files; atan2_rational_approx.sv includes them.
`ifndef ATAN2_RATIONAL_APPROX_MACROS_SVH
`define ATAN2_RATIONAL_APPROX_MACROS_SVH

// Concurrent assertion sampled on the rising clock, switched off during reset.
`define ATAN2RA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Concurrent assertion that is also checked while reset is held.
`define ATAN2RA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[design/atan2ra_pkg.sv]
package atan2ra_pkg;

  localparam int IN_WIDTH_DEF      = 16;
  localparam int OUT_FRAC_BITS_DEF = 13;

  localparam int FRAC      = 16;
  localparam int R_W       = 16;
  localparam int TERM_W    = 17;
  localparam int ANG_W     = 18;
  localparam int DIV_STEPS = 4;

  localparam logic [15:0] K1 = 16'd0;
  localparam logic [15:0] K2 = 16'd65534;
  localparam logic [15:0] K3 = 16'd9663;
  localparam logic [15:0] K4 = 16'd20315;
  localparam logic [15:0] K5 = 16'd3297;
  localparam logic [15:0] K6 = 16'd9641;
  localparam logic [15:0] K7 = 16'd42236;

  localparam logic [TERM_W-1:0] ONE_Q16     = 17'd65536;
  localparam logic [ANG_W-1:0]  HALF_PI_Q16 = 18'd102944;
  localparam logic [ANG_W-1:0]  PI_Q16      = 18'd205887;

  typedef struct packed {
    logic yneg;
    logic xneg;
    logic swap;
    logic sat;
    logic zero;
  } flags_t;

endpackage

[design/atan2ra_div.sv]
module atan2ra_div #(
  parameter int DEN_W = 17,
  parameter int Q_W   = 16,
  parameter int STEPS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  atan2ra_pkg::flags_t side_i,
  input  logic [DEN_W-1:0]   den_i,
  input  logic [DEN_W-1:0]   rem_i,
  input  logic [Q_W-1:0]     low_i,
  output logic               valid_o,
  output atan2ra_pkg::flags_t side_o,
  output logic [Q_W-1:0]     quo_o
);

  localparam int NST = Q_W / STEPS;

  logic                valid_q [NST];
  atan2ra_pkg::flags_t side_q  [NST];
  logic [DEN_W-1:0]    den_q   [NST];
  logic [DEN_W-1:0]    rem_q   [NST];
  logic [Q_W-1:0]      word_q  [NST];

  // The word holds the dividend bits still to come at the top and the
  // quotient bits found so far at the bottom.
  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic                valid_in;
    atan2ra_pkg::flags_t side_in;
    logic [DEN_W-1:0]    den_in;
    logic [DEN_W-1:0]    rem_in;
    logic [Q_W-1:0]      word_in;
    logic [DEN_W-1:0]    rem_d;
    logic [Q_W-1:0]      word_d;

    if (s == 0) begin : g_first
      assign valid_in = valid_i;
      assign side_in  = side_i;
      assign den_in   = den_i;
      assign rem_in   = rem_i;
      assign word_in  = low_i;
    end else begin : g_next
      assign valid_in = valid_q[s-1];
      assign side_in  = side_q[s-1];
      assign den_in   = den_q[s-1];
      assign rem_in   = rem_q[s-1];
      assign word_in  = word_q[s-1];
    end

    always_comb begin
      logic [DEN_W:0] r2;
      logic           ge;
      rem_d  = rem_in;
      word_d = word_in;
      for (int k = 0; k < STEPS; k++) begin
        r2 = {rem_d, word_d[Q_W-1]};
        ge = (r2 >= {1'b0, den_in});
        if (ge) begin
          r2 = r2 - {1'b0, den_in};
        end
        rem_d  = r2[DEN_W-1:0];
        word_d = {word_d[Q_W-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s] <= side_in;
        den_q[s]  <= den_in;
        rem_q[s]  <= rem_d;
        word_q[s] <= word_d;
      end
    end
  end

  assign valid_o = valid_q[NST-1];
  assign side_o  = side_q[NST-1];
  assign quo_o   = word_q[NST-1];

endmodule

[design/atan2_rational_approx.sv]
// Four-quadrant arctangent of a signed (y, x) pair, angle in signed radians with
// OUT_FRAC_BITS fraction bits. One request is taken every clock cycle while the
// output is not stalled. Its result passes through the magnitude register, the
// ratio divider (four quotient bits per stage), the rational approximation (the
// Horner multiplies of numerator and denominator in stages 1 to 4, then the
// rounding offset of the division in stage 5), the final divider and the
// reflections and rounding register. A stall on the output freezes every
// stage, so nothing is lost or repeated.
`include "atan2_rational_approx_macros.svh"

module atan2_rational_approx #(
  parameter int IN_WIDTH      = atan2ra_pkg::IN_WIDTH_DEF,
  parameter int OUT_FRAC_BITS = atan2ra_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [IN_WIDTH-1:0]   y_value_i,
  input  logic signed [IN_WIDTH-1:0]   x_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [OUT_FRAC_BITS+2:0] angle_o
);

  localparam int MW     = IN_WIDTH;
  localparam int OW     = OUT_FRAC_BITS + 3;
  localparam int FRAC   = atan2ra_pkg::FRAC;
  localparam int R_W    = atan2ra_pkg::R_W;
  localparam int TERM_W = atan2ra_pkg::TERM_W;
  localparam int ANG_W  = atan2ra_pkg::ANG_W;
  localparam int PROD_W = TERM_W + R_W;

  logic en;
  logic out_valid_q;
  logic [OW-1:0] angle_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // Stage 0: magnitudes and ordering.
  logic [MW-1:0] ay, ax;
  atan2ra_pkg::flags_t flags_d;

  assign ay = y_value_i[MW-1] ? (~$unsigned(y_value_i) + MW'(1)) : $unsigned(y_value_i);
  assign ax = x_value_i[MW-1] ? (~$unsigned(x_value_i) + MW'(1)) : $unsigned(x_value_i);

  always_comb begin
    flags_d.yneg = y_value_i[MW-1];
    flags_d.xneg = x_value_i[MW-1];
    flags_d.swap = (ay > ax);
    flags_d.zero = (ay == '0) && (ax == '0);
    flags_d.sat  = (ay == ax) && !flags_d.zero;
  end

  logic                s0_valid_q;
  atan2ra_pkg::flags_t s0_flags_q;
  logic [MW-1:0]       s0_hi_q, s0_lo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_flags_q <= flags_d;
      s0_hi_q    <= flags_d.swap ? ay : ax;
      s0_lo_q    <= flags_d.swap ? ax : ay;
    end
  end

  // Ratio divider. Equal or zero magnitudes are settled afterwards.
  logic                d1_valid;
  atan2ra_pkg::flags_t d1_flags;
  logic [R_W-1:0]      d1_quo;
  logic [MW-1:0]       d1_rem;

  assign d1_rem = (s0_flags_q.sat || s0_flags_q.zero) ? '0 : s0_lo_q;

  atan2ra_div #(
    .DEN_W (MW),
    .Q_W   (R_W),
    .STEPS (atan2ra_pkg::DIV_STEPS)
  ) u_ratio_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s0_valid_q),
    .side_i  (s0_flags_q),
    .den_i   (s0_hi_q),
    .rem_i   (d1_rem),
    .low_i   ('0),
    .valid_o (d1_valid),
    .side_o  (d1_flags),
    .quo_o   (d1_quo)
  );

  logic [R_W-1:0] r_d;
  assign r_d = d1_flags.zero ? '0 : (d1_flags.sat ? '1 : d1_quo);

  // Stages 1 to 5: Horner chains of numerator and denominator.
  logic                s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q;
  atan2ra_pkg::flags_t s1_flags_q, s2_flags_q, s3_flags_q, s4_flags_q, s5_flags_q;
  logic [R_W-1:0]      s1_r_q, s2_r_q, s3_r_q;
  logic [31:0]         s1_t_q, s1_d_q;
  logic [PROD_W-1:0]   s2_p_q, s2_e_q, s3_p_q, s4_p_q;
  logic [TERM_W-1:0]   s3_den_q, s4_den_q, s5_den_q;
  logic [2*FRAC+1:0]   s5_dvd_q;

  logic [TERM_W-1:0] n1, e1, n2, n3, num;

  assign n1  = TERM_W'(atan2ra_pkg::K4) - TERM_W'(s1_t_q[31:FRAC]);
  assign e1  = TERM_W'(s1_d_q[31:FRAC]) + TERM_W'(atan2ra_pkg::K6);
  assign n2  = s2_p_q[PROD_W-1:FRAC] + TERM_W'(atan2ra_pkg::K3);
  assign n3  = s3_p_q[PROD_W-1:FRAC] + TERM_W'(atan2ra_pkg::K2);
  assign num = s4_p_q[PROD_W-1:FRAC] + TERM_W'(atan2ra_pkg::K1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= d1_valid;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_flags_q <= d1_flags;
      s1_r_q     <= r_d;
      s1_t_q     <= atan2ra_pkg::K5 * r_d;
      s1_d_q     <= atan2ra_pkg::K7 * r_d;

      s2_flags_q <= s1_flags_q;
      s2_r_q     <= s1_r_q;
      s2_p_q     <= n1 * s1_r_q;
      s2_e_q     <= e1 * s1_r_q;

      s3_flags_q <= s2_flags_q;
      s3_r_q     <= s2_r_q;
      s3_p_q     <= n2 * s2_r_q;
      s3_den_q   <= s2_e_q[PROD_W-1:FRAC] + atan2ra_pkg::ONE_Q16;

      s4_flags_q <= s3_flags_q;
      s4_p_q     <= n3 * s3_r_q;
      s4_den_q   <= s3_den_q;

      s5_flags_q <= s4_flags_q;
      s5_den_q   <= s4_den_q;
      s5_dvd_q   <= {1'b0, num, FRAC'(0)} + (2*FRAC+2)'(s4_den_q >> 1);
    end
  end

  // Final divider: the upper dividend bits are always below the denominator.
  logic                d2_valid;
  atan2ra_pkg::flags_t d2_flags;
  logic [R_W-1:0]      d2_quo;

  atan2ra_div #(
    .DEN_W (TERM_W),
    .Q_W   (R_W),
    .STEPS (atan2ra_pkg::DIV_STEPS)
  ) u_atan_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s5_valid_q),
    .side_i  (s5_flags_q),
    .den_i   (s5_den_q),
    .rem_i   (s5_dvd_q[FRAC+TERM_W-1:FRAC]),
    .low_i   (s5_dvd_q[FRAC-1:0]),
    .valid_o (d2_valid),
    .side_o  (d2_flags),
    .quo_o   (d2_quo)
  );

  // Output stage: octant reflections, rounding and sign.
  logic [ANG_W-1:0] a0, a1, a2;
  logic [OW-1:0]    mag, res;

  assign a0 = ANG_W'(d2_quo);
  assign a1 = !d2_flags.swap ? a0 :
              ((a0 <= atan2ra_pkg::HALF_PI_Q16) ? atan2ra_pkg::HALF_PI_Q16 - a0 : '0);
  assign a2 = !d2_flags.xneg ? a1 :
              ((a1 <= atan2ra_pkg::PI_Q16) ? atan2ra_pkg::PI_Q16 - a1 : '0);

  if (OUT_FRAC_BITS < FRAC) begin : g_round
    localparam int SH = FRAC - OUT_FRAC_BITS;
    logic [ANG_W:0] sum;
    assign sum = {1'b0, a2} + ((ANG_W+1)'(1) << (SH - 1));
    assign mag = OW'(sum >> SH);
  end else begin : g_widen
    assign mag = OW'(a2) << (OUT_FRAC_BITS - FRAC);
  end

  assign res = d2_flags.yneg ? (~mag + OW'(1)) : mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      angle_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign angle_o     = $signed(angle_q);

  `ATAN2RA_ASSERT(a_swap_not_equal, clk_i, rst_ni, s1_valid_q |-> !(s1_flags_q.swap && (s1_flags_q.sat || s1_flags_q.zero)), "swapped item flagged as equal magnitudes")
  `ATAN2RA_ASSERT(a_freeze_on_stall, clk_i, rst_ni, !en |=> ($stable(s1_valid_q) && $stable(s1_r_q)), "pipeline moved while stalled")
  `ATAN2RA_ASSERT(a_num_below_den, clk_i, rst_ni, s5_valid_q |-> (s5_dvd_q[2*FRAC+1:FRAC] < {1'b0, s5_den_q}), "quotient of atan division would overflow")
  `ATAN2RA_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule
